>>> design/chih_pkg.sv
package chih_pkg;

	localparam int ANGLE_STEPS_DEF = 16;
	localparam int ATAN_LEN        = 24;
	localparam int ATAN_IDX_W      = 5;

	// angle units are 1/65536 of a tenth of a degree
	localparam int Z_W    = 27;
	localparam int XY_W   = 28;
	localparam int FULL_W = 28;

	localparam logic [FULL_W-1:0] QUARTER_TURN = FULL_W'(900 * 65536);
	localparam logic [FULL_W-1:0] HALF_TURN    = FULL_W'(1800 * 65536);
	localparam logic [FULL_W-1:0] FULL_TURN    = FULL_W'(3600 * 65536);
	localparam logic [11:0]       TENTHS_WRAP  = 12'd3600;

	typedef struct packed {
		logic               mode;
		logic signed [15:0] mag_x;
		logic signed [15:0] mag_y;
	} in_t;

	typedef struct packed {
		logic [11:0]        heading_tenths;
		logic               heading_valid;
		logic signed [15:0] x_center;
		logic signed [15:0] y_center;
	} out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXT,
		ST_CTR,
		ST_DIFF,
		ST_INIT,
		ST_ITER,
		ST_PLACE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic ext_upd;
		logic ctr;
		logic diff;
		logic init;
		logic iter;
		logic place;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic mode;
		logic last_step;
	} status_t;

	function automatic logic [Z_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
		logic [Z_W-1:0] v;
		unique case (idx)
			5'd0:    v = Z_W'(29491200);
			5'd1:    v = Z_W'(17409672);
			5'd2:    v = Z_W'(9198793);
			5'd3:    v = Z_W'(4669451);
			5'd4:    v = Z_W'(2343786);
			5'd5:    v = Z_W'(1173036);
			5'd6:    v = Z_W'(586661);
			5'd7:    v = Z_W'(293348);
			5'd8:    v = Z_W'(146676);
			5'd9:    v = Z_W'(73339);
			5'd10:   v = Z_W'(36669);
			5'd11:   v = Z_W'(18335);
			5'd12:   v = Z_W'(9167);
			5'd13:   v = Z_W'(4584);
			5'd14:   v = Z_W'(2292);
			5'd15:   v = Z_W'(1146);
			5'd16:   v = Z_W'(573);
			5'd17:   v = Z_W'(286);
			5'd18:   v = Z_W'(143);
			5'd19:   v = Z_W'(72);
			5'd20:   v = Z_W'(36);
			5'd21:   v = Z_W'(18);
			5'd22:   v = Z_W'(9);
			5'd23:   v = Z_W'(4);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

>>> design/chih_ctrl.sv
module chih_ctrl
	import chih_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   emit_ok;

	assign emit_ok   = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_EXT;
			ST_EXT:   state_d = ST_CTR;
			ST_CTR:   state_d = status.mode ? ST_DIFF : ST_EMIT;
			ST_DIFF:  state_d = ST_INIT;
			ST_INIT:  state_d = ST_ITER;
			ST_ITER:  if (status.last_step) state_d = ST_PLACE;
			ST_PLACE: state_d = ST_EMIT;
			ST_EMIT:  if (emit_ok) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_EXT:   cmd.ext_upd = 1'b1;
			ST_CTR:   cmd.ctr     = 1'b1;
			ST_DIFF:  cmd.diff    = 1'b1;
			ST_INIT:  cmd.init    = 1'b1;
			ST_ITER:  cmd.iter    = 1'b1;
			ST_PLACE: cmd.place   = 1'b1;
			ST_EMIT:  cmd.emit    = emit_ok;
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

>>> design/chih_dp.sv
module chih_dp
	import chih_pkg::*;
#(
	parameter int ANGLE_STEPS = ANGLE_STEPS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  in_t     in_data,
	input  cmd_t    cmd,
	output status_t status,
	output out_t    out_data
);

	localparam int STEP_W = $clog2(ANGLE_STEPS);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ANGLE_STEPS - 1);

	in_t                smp_q;
	logic signed [15:0] x_low_q, x_high_q, y_low_q, y_high_q;
	logic signed [15:0] xc_q, yc_q;
	logic signed [16:0] dx_q, dy_q;
	logic               zero_q;
	logic signed [XY_W-1:0] x_q, y_q;
	logic signed [Z_W-1:0]  z_q;
	logic [STEP_W-1:0]      cnt_q;
	logic [FULL_W-1:0]      full_q;
	out_t                   out_q;

	// center: sum of extents halved, truncated toward zero
	logic signed [16:0] xsum, ysum, xsum_adj, ysum_adj;
	assign xsum     = 17'(x_high_q) + 17'(x_low_q);
	assign ysum     = 17'(y_high_q) + 17'(y_low_q);
	assign xsum_adj = xsum + 17'(xsum[16]);
	assign ysum_adj = ysum + 17'(ysum[16]);

	logic [15:0] ax, ay;
	logic [16:0] dx_neg, dy_neg;
	assign dx_neg = -dx_q;
	assign dy_neg = -dy_q;
	assign ax     = dx_q[16] ? dx_neg[15:0] : dx_q[15:0];
	assign ay     = dy_q[16] ? dy_neg[15:0] : dy_q[15:0];

	logic signed [XY_W-1:0] sx, sy;
	logic [Z_W-1:0]         step_angle;
	assign sx         = x_q >>> cnt_q;
	assign sy         = y_q >>> cnt_q;
	assign step_angle = atan_entry(ATAN_IDX_W'(cnt_q));

	// first-quadrant angle clamped to 0..a quarter turn, then placed by quadrant
	logic [FULL_W-1:0] qa, full_d;
	always_comb begin
		if (z_q[Z_W-1])
			qa = '0;
		else if (FULL_W'(z_q) > QUARTER_TURN)
			qa = QUARTER_TURN;
		else
			qa = FULL_W'(z_q);
		case ({dx_q[16], dy_q[16]})
			2'b00:   full_d = qa;
			2'b10:   full_d = HALF_TURN - qa;
			2'b11:   full_d = HALF_TURN + qa;
			default: full_d = FULL_TURN - qa;
		endcase
	end

	logic [FULL_W:0] rounded;
	logic [11:0]     tenths;
	assign rounded = {1'b0, full_q} + (FULL_W+1)'(32768);
	assign tenths  = (rounded[FULL_W:16] >= 13'(TENTHS_WRAP)) ? 12'd0 : rounded[27:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_low_q  <= 16'sd32767;
			x_high_q <= -16'sd32768;
			y_low_q  <= 16'sd32767;
			y_high_q <= -16'sd32768;
		end else if (cmd.ext_upd && !smp_q.mode) begin
			if (smp_q.mag_x < x_low_q)  x_low_q  <= smp_q.mag_x;
			if (smp_q.mag_x > x_high_q) x_high_q <= smp_q.mag_x;
			if (smp_q.mag_y < y_low_q)  y_low_q  <= smp_q.mag_y;
			if (smp_q.mag_y > y_high_q) y_high_q <= smp_q.mag_y;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			smp_q <= in_data;
		if (cmd.ctr) begin
			xc_q <= xsum_adj[16:1];
			yc_q <= ysum_adj[16:1];
		end
		if (cmd.diff) begin
			dx_q <= 17'(smp_q.mag_x) - 17'(xc_q);
			dy_q <= 17'(smp_q.mag_y) - 17'(yc_q);
		end
		if (cmd.init) begin
			x_q    <= XY_W'({ax, 8'd0});
			y_q    <= XY_W'({ay, 8'd0});
			z_q    <= '0;
			cnt_q  <= '0;
			zero_q <= (dx_q == '0) && (dy_q == '0);
		end
		if (cmd.iter) begin
			if (!y_q[XY_W-1]) begin
				x_q <= x_q + sy;
				y_q <= y_q - sx;
				z_q <= z_q + step_angle;
			end else begin
				x_q <= x_q - sy;
				y_q <= y_q + sx;
				z_q <= z_q - step_angle;
			end
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.place)
			full_q <= full_d;
		if (cmd.emit) begin
			out_q.heading_tenths <= (smp_q.mode && !zero_q) ? tenths : 12'd0;
			out_q.heading_valid  <= smp_q.mode;
			out_q.x_center       <= xc_q;
			out_q.y_center       <= yc_q;
		end
	end

	assign status.mode      = smp_q.mode;
	assign status.last_step = (cnt_q == LAST_STEP);
	assign out_data         = out_q;

endmodule

>>> design/compass_hard_iron_heading.sv
// Hard-iron compensated compass heading. Each request carries a raw X/Y
// magnetometer sample and a mode bit. A calibration sample (mode 0) widens the
// stored X/Y min/max and returns the new centers with heading_valid low. A
// heading sample (mode 1) subtracts the centers and returns the angle of the
// offset vector in tenths of a degree, 0..3599, counterclockwise from +X. One
// request is in flight at a time; a result sits in an output register, so the
// next request is taken while it waits. A calibration request passes through
// the extent update, center and emit states. A heading request adds the offset
// subtraction, the CORDIC setup, the CORDIC vectoring loop, which does one
// rotation per cycle on a shared shift-add unit, and quadrant placement before
// its emit state. A result still waiting on out_ready holds the next one back,
// and with it the input.
module compass_hard_iron_heading
	import chih_pkg::*;
#(
	parameter int ANGLE_STEPS = ANGLE_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	cmd_t    cmd;
	status_t status;

	chih_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.cmd      (cmd)
	);

	chih_dp #(
		.ANGLE_STEPS(ANGLE_STEPS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_data (in_data),
		.cmd     (cmd),
		.status  (status),
		.out_data(out_data)
	);

endmodule
